// ----- rtl/ctc_timer_with_period_extension_defines.svh -----
// assertion macros shared by the timer checker
// no dependencies; included by file name where assertions are written
`ifndef CTC_TIMER_WITH_PERIOD_EXTENSION_DEFINES_SVH
`define CTC_TIMER_WITH_PERIOD_EXTENSION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// next-cycle implication, disabled during reset
`define CTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

// ----- rtl/ctc_pkg.sv -----
// shared types, constants and helpers of the clear-on-compare timer
// no dependencies
`default_nettype none

package ctc_pkg;

  localparam int COUNTER_BITS_DEF = 8;
  localparam int MAX_DIVISOR_DEF  = 1024;
  localparam int SKIP_BITS_DEF    = 24;

  localparam int PRESCALE_W = 10;
  localparam int DIV_W      = PRESCALE_W + 1;
  localparam int VALUE_W    = 8;
  localparam int SKIP_CFG_W = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_ENABLE = 3'd0,
    REG_CLOCK_SELECT = 3'd1,
    REG_COMPARE_TOP  = 3'd2,
    REG_SKIP_COUNT   = 3'd3,
    REG_TAIL_RELOAD  = 3'd4
  } ctc_reg_e;

  typedef enum logic [2:0] {
    CS_DIV1    = 3'd0,
    CS_DIV8    = 3'd1,
    CS_DIV64   = 3'd2,
    CS_DIV256  = 3'd3,
    CS_DIV1024 = 3'd4
  } ctc_clk_sel_e;

  typedef struct packed {
    logic                  timer_enable;
    logic [2:0]            clock_select;
    logic [VALUE_W-1:0]    compare_top;
    logic [SKIP_CFG_W-1:0] skip_count;
    logic [VALUE_W-1:0]    tail_reload;
  } ctc_cfg_t;

  typedef struct packed {
    logic               compare_match;
    logic               period_event;
    logic [VALUE_W-1:0] count_value;
  } ctc_res_t;

  // prescaler divisor for a clock select code
  function automatic logic [DIV_W-1:0] divisor(input logic [2:0] sel);
    logic [DIV_W-1:0] d;
    case (sel)
      CS_DIV1:    d = 11'd1;
      CS_DIV8:    d = 11'd8;
      CS_DIV64:   d = 11'd64;
      CS_DIV256:  d = 11'd256;
      CS_DIV1024: d = 11'd1024;
      default:    d = 11'd1;
    endcase
    return d;
  endfunction

  function automatic logic sel_valid(input logic [2:0] sel);
    return sel inside {CS_DIV1, CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ctc_if.sv -----
// valid/ready channel interfaces of the timer: tick input and result output
// no dependencies
`default_nettype none

interface ctc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ctc_result_if;
  logic       valid;
  logic       ready;
  logic       compare_match;
  logic       period_event;
  logic [7:0] count_value;

  modport source (output valid, output compare_match, output period_event,
                  output count_value, input ready);
  modport sink   (input valid, input compare_match, input period_event,
                  input count_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/ctc_core.sv -----
// timer state: prescaler, compare counter, skip counter and tail flag
// depends on ctc_pkg
`default_nettype none

module ctc_core #(
  parameter int COUNTER_BITS = ctc_pkg::COUNTER_BITS_DEF,
  parameter int MAX_DIVISOR  = ctc_pkg::MAX_DIVISOR_DEF,
  parameter int SKIP_BITS    = ctc_pkg::SKIP_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              tick_i,
  input  wire ctc_pkg::ctc_cfg_t cfg_i,
  output ctc_pkg::ctc_res_t      res_o
);

  localparam logic [ctc_pkg::DIV_W-1:0] MaxDiv = ctc_pkg::DIV_W'(MAX_DIVISOR);

  logic [ctc_pkg::PRESCALE_W-1:0] presc_q, presc_d;
  logic [COUNTER_BITS-1:0]        count_q, count_d;
  logic [SKIP_BITS-1:0]           skipped_q, skipped_d;
  logic                           tail_q, tail_d;

  logic [ctc_pkg::DIV_W-1:0] div_tbl, div;
  logic [ctc_pkg::DIV_W-1:0] presc_inc;
  logic [COUNTER_BITS-1:0]   top;
  logic [31:0]               skip_ext;
  logic [SKIP_BITS-1:0]      skip_lim;
  logic [SKIP_BITS-1:0]      skipped_inc;
  logic                      run, match, evt;

  assign div_tbl   = ctc_pkg::divisor(cfg_i.clock_select);
  assign div       = (div_tbl > MaxDiv) ? MaxDiv : div_tbl;
  assign presc_inc = {1'b0, presc_q} + 1'b1;
  assign skip_ext  = {8'd0, cfg_i.skip_count};
  assign skip_lim  = skip_ext[SKIP_BITS-1:0];
  assign skipped_inc = (skipped_q != '1) ? skipped_q + 1'b1 : skipped_q;

  // an empty tail reload leaves the counter running to all ones
  always_comb begin
    if (tail_q) begin
      if (cfg_i.tail_reload == '0) begin
        top = '1;
      end else begin
        top = COUNTER_BITS'(cfg_i.tail_reload) - 1'b1;
      end
    end else begin
      top = COUNTER_BITS'(cfg_i.compare_top);
    end
  end

  assign run = tick_i && cfg_i.timer_enable && ctc_pkg::sel_valid(cfg_i.clock_select);

  always_comb begin
    presc_d   = presc_q;
    count_d   = count_q;
    skipped_d = skipped_q;
    tail_d    = tail_q;
    match     = 1'b0;
    evt       = 1'b0;
    if (run) begin
      if (presc_inc >= div) begin
        presc_d = '0;
        if (count_q == top) begin
          count_d = '0;
          match   = 1'b1;
          if (skip_lim == '0 || tail_q) begin
            skipped_d = '0;
            tail_d    = 1'b0;
            evt       = 1'b1;
          end else begin
            skipped_d = skipped_inc;
            if (skipped_inc >= skip_lim) begin
              if (cfg_i.tail_reload != '0) begin
                tail_d = 1'b1;
              end else begin
                skipped_d = '0;
                evt       = 1'b1;
              end
            end
          end
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        presc_d = presc_inc[ctc_pkg::PRESCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q   <= '0;
      count_q   <= '0;
      skipped_q <= '0;
      tail_q    <= 1'b0;
    end else if (step_i) begin
      presc_q   <= presc_d;
      count_q   <= count_d;
      skipped_q <= skipped_d;
      tail_q    <= tail_d;
    end
  end

  assign res_o.compare_match = match;
  assign res_o.period_event  = evt;
  assign res_o.count_value   = count_d[ctc_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/ctc_timer_with_period_extension.sv -----
// top level of the clear-on-compare timer with period extension
// depends on ctc_pkg, ctc_if (ctc_tick_if, ctc_result_if) and ctc_core
//
//   channel   dir  contents                                      handshake
//   in_i      in   tick                                          valid/ready
//   out_o     out  compare_match, period_event, count_value      valid/ready
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i              write enable
//
// one transaction per cycle unless the output stalls; each result passes the input
// register, which feeds the state update and the result register in one pass
// a stalled output holds both stages; the input register keeps taking while the
// result register drains, so ready only drops when both stages are full and stalled
// reset clears the configuration, the timer state and both valid flags
`default_nettype none

module ctc_timer_with_period_extension #(
  parameter int COUNTER_BITS = ctc_pkg::COUNTER_BITS_DEF,
  parameter int MAX_DIVISOR  = ctc_pkg::MAX_DIVISOR_DEF,
  parameter int SKIP_BITS    = ctc_pkg::SKIP_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ctc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ctc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ctc_tick_if.sink                            in_i,
  ctc_result_if.source                        out_o
);

  ctc_pkg::ctc_cfg_t cfg_q;
  ctc_pkg::ctc_res_t res_d, res_q;

  logic in_valid_q, out_valid_q;
  logic tick_q;
  logic advance, in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctc_pkg::REG_TIMER_ENABLE: cfg_q.timer_enable <= cfg_wdata_i[0];
        ctc_pkg::REG_CLOCK_SELECT: cfg_q.clock_select <= cfg_wdata_i[2:0];
        ctc_pkg::REG_COMPARE_TOP:  cfg_q.compare_top  <= cfg_wdata_i[ctc_pkg::VALUE_W-1:0];
        ctc_pkg::REG_SKIP_COUNT:   cfg_q.skip_count   <= cfg_wdata_i[ctc_pkg::SKIP_CFG_W-1:0];
        ctc_pkg::REG_TAIL_RELOAD:  cfg_q.tail_reload  <= cfg_wdata_i[ctc_pkg::VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tick_q <= in_i.tick;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  ctc_core #(
    .COUNTER_BITS (COUNTER_BITS),
    .MAX_DIVISOR  (MAX_DIVISOR),
    .SKIP_BITS    (SKIP_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && in_valid_q),
    .tick_i (tick_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.compare_match = res_q.compare_match;
  assign out_o.period_event  = res_q.period_event;
  assign out_o.count_value   = res_q.count_value;

endmodule

`default_nettype wire

// ----- rtl/ctc_checker.sv -----
// port-level checks of the timer, bound to the top level
// depends on ctc_timer_with_period_extension_defines.svh and the top level
`default_nettype none
`include "ctc_timer_with_period_extension_defines.svh"

module ctc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       compare_match_i,
  input wire logic       period_event_i,
  input wire logic [7:0] count_value_i
);

  // an event only closes a period on a compare match
  `CTC_ASSERT_IMP(a_event_on_match, clk_i, rst_ni, out_valid_i && period_event_i,
                  compare_match_i)

  // a match always clears the counter
  `CTC_ASSERT_IMP(a_match_clears, clk_i, rst_ni, out_valid_i && compare_match_i,
                  count_value_i == 8'd0)

  // a fresh result comes from a tick accepted through the input register
  `CTC_ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(out_valid_i),
                  $past(in_valid_i && in_ready_i, 2))

  // a stalled result stays put
  `CTC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(compare_match_i) && $stable(period_event_i) &&
                  $stable(count_value_i))

endmodule

bind ctc_timer_with_period_extension ctc_checker u_ctc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .compare_match_i (out_o.compare_match),
  .period_event_i  (out_o.period_event),
  .count_value_i   (out_o.count_value)
);

`default_nettype wire
